// ===== rtl/csx_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, register codes and binary32 helper functions for the complex AXPY core.
// It has no dependencies. csx_fmul, csx_fadd and the core use it.
package csx_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_ALPHA_REAL = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ALPHA_IMAG = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_VEC_LEN    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_X_STRIDE   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_Y_STRIDE   = 3'd4;

  localparam logic [31:0] CANON_NAN    = 32'h7FC0_0000;
  localparam logic [31:0] STRIDE_RESET = 32'd1;

  typedef struct packed {
    logic [31:0] element_index;
    logic [31:0] x_real;
    logic [31:0] x_imag;
    logic [31:0] y_real;
    logic [31:0] y_imag;
  } in_item_t;

  typedef struct packed {
    logic [31:0] sum_real;
    logic [31:0] sum_imag;
    logic [62:0] x_element_offset;
    logic [62:0] y_element_offset;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [31:0]        value;
  } cfg_req_t;

  // Position of the most significant set bit; zero for an all-zero word.
  function automatic logic [5:0] lead_one(input logic [47:0] v);
    logic [5:0] pos;
    pos = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) pos = 6'(i);
    end
    return pos;
  endfunction

  // Rounds to nearest even and packs. A subnormal mantissa has bit 23 clear,
  // and a carry out of the fraction moves naturally into the exponent field.
  function automatic logic [31:0] round_pack(input logic sign, input logic signed [12:0] e,
                                             input logic [23:0] m, input logic g,
                                             input logic s);
    logic [7:0]  ef;
    logic [30:0] body;
    logic        up;
    ef   = m[23] ? e[7:0] : 8'd0;
    up   = g & (s | m[0]);
    body = {ef, m[22:0]} + {30'd0, up};
    if (e >= 13'sd255) begin
      return {sign, 8'hFF, 23'd0};
    end
    return {sign, body};
  endfunction

endpackage

// ===== rtl/csx_chan_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload of type T per request.
// The payload types come from csx_pkg.
interface csx_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/csx_fmul.sv =====
`timescale 1ns / 1ps
// Two-stage binary32 multiplier: mantissa product, then normalise and round.
// Uses csx_pkg for the leading-one search and the rounding helper.
module csx_fmul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] p
);

  logic [7:0]         ea, eb, eae, ebe;
  logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [47:0]        prod_nxt, prod_r;
  logic signed [12:0] exp_nxt, exp_r;
  logic               sign_r, nan_r, inf_r, zero_r;
  logic               nan_nxt, inf_nxt, zero_nxt;

  logic [5:0]         pos;
  logic signed [12:0] e, eo, rdist;
  logic [47:0]        norm_l, n;
  logic [5:0]         rsh;
  logic               lost;
  logic [31:0]        p_nxt, p_r;

  always_comb begin
    ea       = a[30:23];
    eb       = b[30:23];
    eae      = (ea == 8'd0) ? 8'd1 : ea;
    ebe      = (eb == 8'd0) ? 8'd1 : eb;
    a_nan    = (ea == 8'hFF) && (a[22:0] != 23'd0);
    b_nan    = (eb == 8'hFF) && (b[22:0] != 23'd0);
    a_inf    = (ea == 8'hFF) && (a[22:0] == 23'd0);
    b_inf    = (eb == 8'hFF) && (b[22:0] == 23'd0);
    a_zero   = (ea == 8'd0) && (a[22:0] == 23'd0);
    b_zero   = (eb == 8'd0) && (b[22:0] == 23'd0);
    nan_nxt  = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
    inf_nxt  = (a_inf | b_inf) & ~nan_nxt;
    zero_nxt = (a_zero | b_zero) & ~nan_nxt & ~inf_nxt;
    prod_nxt = {24'd0, |ea, a[22:0]} * {24'd0, |eb, b[22:0]};
    exp_nxt  = $signed({5'd0, eae}) + $signed({5'd0, ebe}) - 13'sd127;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      exp_r  <= exp_nxt;
      sign_r <= a[31] ^ b[31];
      nan_r  <= nan_nxt;
      inf_r  <= inf_nxt;
      zero_r <= zero_nxt;
    end
  end

  always_comb begin
    pos    = csx_pkg::lead_one(prod_r);
    e      = exp_r + $signed({7'd0, pos}) - 13'sd46;
    norm_l = prod_r << (6'd47 - pos);
    rdist  = 13'sd1 - e;
    if (e >= 13'sd1) begin
      rsh = 6'd0;
    end else if (rdist > 13'sd49) begin
      rsh = 6'd49;
    end else begin
      rsh = rdist[5:0];
    end
    n    = norm_l >> rsh;
    lost = |(norm_l & ~({48{1'b1}} << rsh));
    eo   = (e >= 13'sd1) ? e : 13'sd0;
    if (nan_r) begin
      p_nxt = csx_pkg::CANON_NAN;
    end else if (inf_r) begin
      p_nxt = {sign_r, 8'hFF, 23'd0};
    end else if (zero_r) begin
      p_nxt = {sign_r, 31'd0};
    end else begin
      p_nxt = csx_pkg::round_pack(sign_r, eo, n[47:24], n[23], (|n[22:0]) | lost);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

// ===== rtl/csx_fadd.sv =====
`timescale 1ns / 1ps
// Two-stage binary32 adder: order and align, then add, normalise and round.
// Uses csx_pkg for the leading-one search and the rounding helper.
module csx_fadd (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] s
);

  logic [31:0]        big, sml;
  logic [7:0]         ebb, ebs, dexp;
  logic [4:0]         ash;
  logic [26:0]        mbig_nxt, msml, al_nxt;
  logic               a_nan, b_nan, a_inf, b_inf;
  logic               nan_nxt, inf_nxt, inf_sign_nxt;

  logic [26:0]        mbig_r, al_r;
  logic [7:0]         ebe_r;
  logic               sign_r, sub_r, nan_r, inf_r, inf_sign_r;

  logic [27:0]        sum;
  logic [5:0]         pos;
  logic [4:0]         lz;
  logic [26:0]        n;
  logic signed [12:0] e;
  logic [31:0]        s_nxt, s_r;

  always_comb begin
    a_nan        = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan        = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf        = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf        = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    nan_nxt      = a_nan | b_nan | (a_inf & b_inf & (a[31] ^ b[31]));
    inf_nxt      = (a_inf | b_inf) & ~nan_nxt;
    inf_sign_nxt = a_inf ? a[31] : b[31];
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    ebb      = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    ebs      = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    dexp     = ebb - ebs;
    ash      = (dexp > 8'd31) ? 5'd31 : dexp[4:0];
    mbig_nxt = {|big[30:23], big[22:0], 3'd0};
    msml     = {|sml[30:23], sml[22:0], 3'd0};
    al_nxt   = msml >> ash;
    // Bits shifted out of the smaller operand fold into the sticky bit.
    al_nxt[0] = al_nxt[0] | (|(msml & ~({27{1'b1}} << ash)));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mbig_r     <= mbig_nxt;
      al_r       <= al_nxt;
      ebe_r      <= ebb;
      sign_r     <= big[31];
      sub_r      <= big[31] ^ sml[31];
      nan_r      <= nan_nxt;
      inf_r      <= inf_nxt;
      inf_sign_r <= inf_sign_nxt;
    end
  end

  always_comb begin
    sum = sub_r ? ({1'b0, mbig_r} - {1'b0, al_r}) : ({1'b0, mbig_r} + {1'b0, al_r});
    pos = csx_pkg::lead_one({20'd0, sum});
    lz  = 5'd0;
    if (pos == 6'd27) begin
      n = {sum[27:2], sum[1] | sum[0]};
      e = $signed({5'd0, ebe_r}) + 13'sd1;
    end else begin
      lz = 5'(6'd26 - pos);
      if ({3'd0, lz} < ebe_r) begin
        n = sum[26:0] << lz;
        e = $signed({5'd0, ebe_r}) - $signed({8'd0, lz});
      end else begin
        n = sum[26:0] << (ebe_r - 8'd1);
        e = 13'sd0;
      end
    end
    if (nan_r) begin
      s_nxt = csx_pkg::CANON_NAN;
    end else if (inf_r) begin
      s_nxt = {inf_sign_r, 8'hFF, 23'd0};
    end else if (sum == 28'd0) begin
      // An exact zero is positive unless both operands were negative zeros.
      s_nxt = {sign_r & ~sub_r, 31'd0};
    end else begin
      s_nxt = csx_pkg::round_pack(sign_r, e, n[26:3], n[2], |n[1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
    end
  end

  assign s = s_r;

endmodule

// ===== rtl/csx_offset.sv =====
`timescale 1ns / 1ps
// Three-stage strided element offset: position and magnitude, two 32-bit products, sum.
// Stands alone; instantiated twice by the core.
module csx_offset (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] stride,
  input  logic [31:0] vec_len,
  input  logic [31:0] index,
  output logic [62:0] offset
);

  logic        neg;
  logic [63:0] pos;
  logic [31:0] mag_nxt, mag_r, pl_r;
  logic [30:0] ph_r;
  logic [63:0] lo_nxt, lo_r;
  logic [62:0] hi_full;
  logic [30:0] hi_r;
  logic [62:0] off_r;

  always_comb begin
    neg     = stride[31];
    mag_nxt = neg ? (~stride + 32'd1) : stride;
    pos     = neg ? ({32'd0, vec_len} - 64'd1 - {32'd0, index}) : {32'd0, index};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_nxt;
      pl_r  <= pos[31:0];
      ph_r  <= pos[62:32];
    end
  end

  // Only the low 63 bits are kept, so the upper half needs 31 bits of its product.
  always_comb begin
    lo_nxt  = {32'd0, pl_r} * {32'd0, mag_r};
    hi_full = {32'd0, ph_r} * {31'd0, mag_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_full[30:0];
      off_r <= lo_r[62:0] + {hi_r, 32'd0};
    end
  end

  assign offset = off_r;

endmodule

// ===== rtl/complex_saxpy_element_core.sv =====
`timescale 1ns / 1ps
// Complex single-precision AXPY core, one element per request: y' = alpha*x + y.
// Depends on csx_pkg, csx_chan_if, csx_fmul, csx_fadd and csx_offset.
//
// Channels: in_chan takes an element index and the binary32 parts of x and y;
// out_chan returns both parts of the sum and the strided offsets of x and y;
// cfg_chan writes alpha, the vector length and the two strides, and is always ready.
// Configuration must be written only while no element is in flight (not enforced).
// The pipeline from an accepted request to its result on out_chan has
// two stages of multiplication, two for the first addition (real difference
// and imaginary sum) and two for the addition of y. The offsets are computed
// alongside in csx_offset and are delayed to match.
// Throughput is one element per cycle and a new request may follow every cycle, while out_chan does not stall.
// Reset (rst_n low at a clock edge) empties the pipeline and sets alpha and
// the vector length to zero and both strides to one.
// When out_chan is not ready while a result waits, the whole pipeline holds
// and in_chan.ready drops; bubbles further up are not squeezed out, and only
// an empty output slot or a ready out_chan keeps in_chan.ready high.
module complex_saxpy_element_core (
  input  logic clk,
  input  logic rst_n,
  csx_chan_if.sink   in_chan,
  csx_chan_if.source out_chan,
  csx_chan_if.sink   cfg_chan
);

  localparam int unsigned Depth = 6;

  csx_pkg::in_item_t  req;
  csx_pkg::cfg_req_t  creq;
  csx_pkg::out_item_t res;

  logic [31:0] alpha_re_r, alpha_im_r, vec_len_r, x_stride_r, y_stride_r;
  logic [Depth-1:0] vld_r;
  logic        adv;

  logic [31:0] p0, p1, p2, p3, dif, smm, re, im;
  logic [31:0] yr_r [4];
  logic [31:0] yi_r [4];
  logic [62:0] xoff, yoff;
  logic [62:0] xoff_r [3];
  logic [62:0] yoff_r [3];

  assign req  = in_chan.data;
  assign creq = cfg_chan.data;

  // The pipeline moves whenever the output slot is empty or being taken.
  assign adv           = ~vld_r[Depth-1] | out_chan.ready;
  assign in_chan.ready = adv;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_re_r <= '0;
      alpha_im_r <= '0;
      vec_len_r  <= '0;
      x_stride_r <= csx_pkg::STRIDE_RESET;
      y_stride_r <= csx_pkg::STRIDE_RESET;
    end else if (cfg_chan.valid) begin
      case (creq.index)
        csx_pkg::REG_ALPHA_REAL: alpha_re_r <= creq.value;
        csx_pkg::REG_ALPHA_IMAG: alpha_im_r <= creq.value;
        csx_pkg::REG_VEC_LEN:    vec_len_r  <= creq.value;
        csx_pkg::REG_X_STRIDE:   x_stride_r <= creq.value;
        csx_pkg::REG_Y_STRIDE:   y_stride_r <= creq.value;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[Depth-2:0], in_chan.valid};
    end
  end

  csx_fmul u_mul_p0 (.clk(clk), .en(adv), .a(alpha_re_r), .b(req.x_real), .p(p0));
  csx_fmul u_mul_p1 (.clk(clk), .en(adv), .a(alpha_im_r), .b(req.x_imag), .p(p1));
  csx_fmul u_mul_p2 (.clk(clk), .en(adv), .a(alpha_re_r), .b(req.x_imag), .p(p2));
  csx_fmul u_mul_p3 (.clk(clk), .en(adv), .a(alpha_im_r), .b(req.x_real), .p(p3));

  // Subtraction is addition with the sign of the second product flipped.
  csx_fadd u_add_dif (.clk(clk), .en(adv), .a(p0), .b({~p1[31], p1[30:0]}), .s(dif));
  csx_fadd u_add_smm (.clk(clk), .en(adv), .a(p2), .b(p3), .s(smm));

  csx_fadd u_add_re (.clk(clk), .en(adv), .a(dif), .b(yr_r[3]), .s(re));
  csx_fadd u_add_im (.clk(clk), .en(adv), .a(smm), .b(yi_r[3]), .s(im));

  csx_offset u_off_x (
    .clk(clk), .en(adv), .stride(x_stride_r), .vec_len(vec_len_r),
    .index(req.element_index), .offset(xoff)
  );
  csx_offset u_off_y (
    .clk(clk), .en(adv), .stride(y_stride_r), .vec_len(vec_len_r),
    .index(req.element_index), .offset(yoff)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      yr_r[0]   <= req.y_real;
      yi_r[0]   <= req.y_imag;
      for (int i = 1; i < 4; i++) begin
        yr_r[i] <= yr_r[i-1];
        yi_r[i] <= yi_r[i-1];
      end
      xoff_r[0] <= xoff;
      yoff_r[0] <= yoff;
      for (int i = 1; i < 3; i++) begin
        xoff_r[i] <= xoff_r[i-1];
        yoff_r[i] <= yoff_r[i-1];
      end
    end
  end

  always_comb begin
    res.sum_real         = re;
    res.sum_imag         = im;
    res.x_element_offset = xoff_r[2];
    res.y_element_offset = yoff_r[2];
  end

  assign out_chan.valid = vld_r[Depth-1];
  assign out_chan.data  = res;

endmodule
